// File: design/upd_pkg.sv
// Shared types, character constants and helpers of the percent decoder.
package upd_pkg;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam int unsigned UPD_QUEUE_DEPTH = 4;

	// Escape phase of the front part, one-hot.
	typedef enum logic [2:0] {
		PH_PLAIN = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	// Up to three decoded bytes produced by one input item.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            last;
	} bundle_t;

	typedef struct packed {
		logic    push;
		bundle_t data;
	} q_wr_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} q_head_t;

	function automatic logic is_hex(input logic [7:0] ch);
		return ((ch >= CH_0) && (ch <= CH_9)) || ((ch >= CH_LA) && (ch <= CH_LF)) ||
			((ch >= CH_UA) && (ch <= CH_UF));
	endfunction

	// Nibble of a character already known to be a hex digit.
	function automatic logic [3:0] nibble_of(input logic [7:0] ch);
		if (ch <= CH_9) begin
			return ch[3:0];
		end
		return ch[3:0] + 4'd9;
	endfunction

endpackage

// File: design/upd_in_if.sv
// Stream interface that carries encoded input items.
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// File: design/upd_out_if.sv
// Stream interface that carries decoded result items.
interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// File: design/upd_front.sv
// Front part: accepts encoded items, tracks the escape phase, builds result bundles.
module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	upd_in_if.sink     enc,
	input  logic       q_full,
	output q_wr_t      q_wr
);

	phase_t     phase_q, nxt_phase;
	logic [7:0] held_q, nxt_held;
	logic [3:0][7:0] by;
	logic [1:0] n;
	logic       plain_run;
	logic       hex;
	logic       acc;

	assign enc.ready = !q_full;
	assign acc = enc.valid && enc.ready;

	always_comb begin
		hex       = is_hex(enc.in_byte);
		nxt_phase = phase_q;
		nxt_held  = held_q;
		by        = '0;
		n         = 2'd0;
		plain_run = 1'b0;
		case (phase_q)
			PH_PCT: begin
				if (hex) begin
					nxt_phase = PH_DIGIT;
					nxt_held  = enc.in_byte;
				end else begin
					by[0]     = CH_PCT;
					n         = 2'd1;
					plain_run = 1'b1;
					nxt_phase = PH_PLAIN;
				end
			end
			PH_DIGIT: begin
				nxt_phase = PH_PLAIN;
				nxt_held  = '0;
				if (hex) begin
					by[0] = {nibble_of(held_q), nibble_of(enc.in_byte)};
					n     = 2'd1;
				end else begin
					by[0]     = CH_PCT;
					by[1]     = held_q;
					n         = 2'd2;
					plain_run = 1'b1;
				end
			end
			default: begin
				plain_run = 1'b1;
				nxt_phase = PH_PLAIN;
			end
		endcase

		if (plain_run) begin
			if (enc.in_byte == CH_PLUS) begin
				by[n] = CH_SPACE;
				n     = n + 2'd1;
			end else if (enc.in_byte == CH_PCT) begin
				nxt_phase = PH_PCT;
				nxt_held  = '0;
			end else begin
				by[n] = enc.in_byte;
				n     = n + 2'd1;
			end
		end

		// End of string: flush whatever escape is still open.
		if (enc.in_last) begin
			if (nxt_phase == PH_PCT) begin
				by[n] = CH_PCT;
				n     = n + 2'd1;
			end else if (nxt_phase == PH_DIGIT) begin
				by[n] = CH_PCT;
				n     = n + 2'd1;
				by[n] = nxt_held;
				n     = n + 2'd1;
			end
			nxt_phase = PH_PLAIN;
			nxt_held  = '0;
		end

		q_wr.push       = acc && (n != 2'd0);
		q_wr.data.bytes = by[2:0];
		q_wr.data.cnt   = n;
		q_wr.data.last  = enc.in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			held_q  <= '0;
		end else if (acc) begin
			phase_q <= nxt_phase;
			held_q  <= nxt_held;
		end
	end

	a_last_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && enc.in_last) |=> (phase_q == PH_PLAIN))
		else $error("escape phase not cleared after the last item of a string");

endmodule

// File: design/upd_queue.sv
// Short queue of result bundles between the front and the back part.
module upd_queue import upd_pkg::*; #(
	parameter int unsigned DEPTH = UPD_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_wr_t   q_wr,
	output logic    full,
	output q_head_t head,
	input  logic    pop
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.data  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		if (p == AW'(DEPTH - 1)) begin
			return '0;
		end
		return p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (q_wr.push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!q_wr.push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_wr.push && full))
		else $error("bundle pushed into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");

endmodule

// File: design/upd_back.sv
// Back part: unpacks result bundles into single output items.
module upd_back import upd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_head_t head,
	output logic    pop,
	upd_out_if.source dec
);

	bundle_t    cur_q;
	logic       cur_vld_q;
	logic [1:0] idx_q;
	logic       at_end;
	logic       load;

	assign at_end       = (idx_q == (cur_q.cnt - 2'd1));
	assign dec.valid    = cur_vld_q;
	assign dec.out_byte = cur_q.bytes[idx_q];
	assign dec.out_last = cur_q.last && at_end;
	assign load         = !cur_vld_q || (dec.ready && at_end);
	assign pop          = load && head.valid;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (load) begin
			cur_vld_q <= head.valid;
			idx_q     <= '0;
		end else if (dec.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	a_bundle_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> (cur_q.cnt != 2'd0))
		else $error("empty bundle reached the output stage");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> (idx_q < cur_q.cnt))
		else $error("output index beyond bundle size");

endmodule

// File: design/url_percent_decoder.sv
// Top level of the form-URL-encoded stream decoder.
//
//   channel  role    payload              item
//   enc      sink    in_byte, in_last     one encoded character
//   dec      source  out_byte, out_last   one decoded byte
//
// Cycles: an encoded item is taken every cycle while the bundle queue has room.
// Each item yields zero to three decoded items, and the output stage sends one
// per cycle while dec is ready, so the output port sets the overall rate.
// A result goes through the bundle queue and the output register on its way to dec.
// Reset clears the escape phase, the queue pointers and the output stage.
// A stall on dec fills the queue and then drops enc.ready; enc never stalls dec.
module url_percent_decoder import upd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = UPD_QUEUE_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	upd_in_if.sink      enc,
	upd_out_if.source   dec
);

	// Front to queue: bundle push; queue to front: full flag.
	q_wr_t   q_wr;
	logic    q_full;
	// Queue to back: oldest bundle; back to queue: pop request.
	q_head_t q_head;
	logic    q_pop;

	// The front decides, per input item, which bytes come out and updates the
	// escape phase; items that produce nothing are not queued at all.
	upd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	// The queue lets a malformed burst of three bytes sit while new input is
	// still taken, so the two sides stall independently.
	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.full   (q_full),
		.head   (q_head),
		.pop    (q_pop)
	);

	// The back holds one bundle in its output register and steps through it.
	upd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.dec    (dec)
	);

endmodule

// File: test/tb_top.sv
// Self-checking testbench of the form-URL-encoded stream decoder.
module tb_top import upd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Run shape. The decoder has no configuration registers, so there are no setting phases.
	localparam int RANDOM_ITEMS = 340;
	localparam int HOLD_CYCLES  = 48;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 8;

	// One encoded item of stimulus. A count of -1 means the expected decoded
	// bytes come from the predictor; otherwise the row carries them itself.
	typedef struct {
		logic [7:0]      ch;
		logic            last;
		int              n;
		logic [2:0][7:0] outs;
	} stim_row_t;

	// One decoded item as it should leave the block.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} dec_item_t;

	logic clk;
	logic arst_n;

	upd_in_if  enc_bus ();
	upd_out_if dec_bus ();

	url_percent_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc_bus),
		.dec    (dec_bus)
	);

	// Predictor state: where we are inside a percent escape and which first
	// digit is being held.
	phase_t     esc_phase;
	logic [7:0] held_char;

	// Decoded items still owed by the block, oldest first.
	dec_item_t expected_bytes [$];

	int  errors;
	int  items_sent;
	int  strings_sent;
	int  results_checked;
	int  holds_done;
	int  drains_done;

	// Sender pacing. The burst counter sets how many items go back to back;
	// the no-gap counter forces a long run while the receiver holds off.
	int  burst_left;
	int  no_gap_left;
	bit  drain_req;

	// Raised by the sender side to ask the receiver for one long hold-off.
	bit  hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic stim_row_t row(input logic [7:0] ch, input logic last, input int n = -1,
			input logic [7:0] b0 = 8'h00, input logic [7:0] b1 = 8'h00,
			input logic [7:0] b2 = 8'h00);
		stim_row_t r;
		r.ch      = ch;
		r.last    = last;
		r.n       = n;
		r.outs[0] = b0;
		r.outs[1] = b1;
		r.outs[2] = b2;
		return r;
	endfunction

	// Value of a hex digit character in either case, or -1 for anything else.
	function automatic int hex_value(input logic [7:0] ch);
		if (ch >= CH_0 && ch <= CH_9) begin
			return int'(ch - CH_0);
		end
		if (ch >= CH_LA && ch <= CH_LF) begin
			return int'(ch - CH_LA) + 10;
		end
		if (ch >= CH_UA && ch <= CH_UF) begin
			return int'(ch - CH_UA) + 10;
		end
		return -1;
	endfunction

	function automatic logic [7:0] rand_hex();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	// A character seen outside an escape: '+' becomes a space, '%' opens an
	// escape and yields nothing yet, anything else passes through.
	task automatic plain_char(input logic [7:0] ch, inout int n, inout logic [2:0][7:0] outs);
		if (ch == CH_PLUS) begin
			outs[n] = CH_SPACE;
			n++;
		end else if (ch == CH_PCT) begin
			esc_phase = PH_PCT;
			held_char = 8'h00;
		end else begin
			outs[n] = ch;
			n++;
		end
	endtask

	// Predictor: advances the escape state by one encoded character and
	// returns the decoded bytes it releases, at most three.
	task automatic decode_char(input logic [7:0] ch, input logic last, output int n,
			output logic [2:0][7:0] outs);
		int lo;
		int hi;
		n    = 0;
		outs = '0;
		lo   = hex_value(ch);
		case (esc_phase)
			PH_PCT: begin
				if (lo >= 0) begin
					held_char = ch;
					esc_phase = PH_DIGIT;
				end else begin
					// A broken escape right after '%': the '%' goes out as is and
					// the breaking character is handled as plain text.
					esc_phase = PH_PLAIN;
					outs[n] = CH_PCT;
					n++;
					plain_char(ch, n, outs);
				end
			end
			PH_DIGIT: begin
				hi = hex_value(held_char);
				if (lo >= 0 && hi >= 0) begin
					outs[n] = {hi[3:0], lo[3:0]};
					n++;
				end else begin
					// Broken after one digit: '%' and the held digit go out literally.
					outs[n]     = CH_PCT;
					outs[n + 1] = held_char;
					n += 2;
				end
				esc_phase = PH_PLAIN;
				held_char = 8'h00;
				if (!(lo >= 0 && hi >= 0)) begin
					plain_char(ch, n, outs);
				end
			end
			default: begin
				esc_phase = PH_PLAIN;
				plain_char(ch, n, outs);
			end
		endcase
		// At the end of a string whatever escape is still open is flushed literally.
		if (last) begin
			if (esc_phase == PH_PCT) begin
				outs[n] = CH_PCT;
				n++;
			end else if (esc_phase == PH_DIGIT) begin
				outs[n]     = CH_PCT;
				outs[n + 1] = held_char;
				n += 2;
			end
			esc_phase = PH_PLAIN;
			held_char = 8'h00;
		end
	endtask

	// Offers one encoded item and waits for its handshake. Called just after a
	// rising edge; returns at the edge that accepted the item, at which point
	// the decoded bytes it causes are queued.
	task automatic send_char(input stim_row_t r);
		int              n;
		logic [2:0][7:0] outs;
		enc_bus.valid   <= 1'b1;
		enc_bus.in_byte <= r.ch;
		enc_bus.in_last <= r.last;
		@(posedge clk);
		while (!enc_bus.ready) begin
			@(posedge clk);
		end
		items_sent++;
		if (r.last) begin
			strings_sent++;
		end
		decode_char(r.ch, r.last, n, outs);
		if (r.n >= 0) begin
			n    = r.n;
			outs = r.outs;
		end
		for (int k = 0; k < n; k++) begin
			expected_bytes.push_back('{data: outs[k], last: r.last && (k == n - 1)});
		end
	endtask

	// Decides what the sender does after an accepted item. Every branch that
	// lowers valid waits on the clock before it returns, so the next send_char
	// never assigns valid twice in one time step.
	task automatic pace();
		if (drain_req) begin
			// Pause until the block has handed over everything it owes.
			enc_bus.valid <= 1'b0;
			do begin
				@(posedge clk);
			end while (expected_bytes.size() != 0);
			drain_req = 1'b0;
			drains_done++;
		end else if (no_gap_left > 0) begin
			no_gap_left--;
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			enc_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = $urandom_range(0, 20);
		end
	endtask

	// A random string. Most of it is made of well-formed escapes with random
	// digits, mixed with '+', broken escapes and arbitrary bytes. A broken
	// escape at the very end of the string exercises the flush on the last flag.
	task automatic send_random_string();
		int         target;
		int         kind;
		logic [7:0] chars [$];
		target = $urandom_range(1, 12);
		while (chars.size() < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				chars.push_back(CH_PCT);
				chars.push_back(rand_hex());
				chars.push_back(rand_hex());
			end else if (kind < 52) begin
				chars.push_back(CH_PLUS);
			end else if (kind < 62) begin
				chars.push_back(CH_PCT);
				if ($urandom_range(0, 1) == 1) begin
					chars.push_back(rand_hex());
				end
				case ($urandom_range(0, 3))
					0: chars.push_back(8'($urandom_range(0, 255)));
					1: chars.push_back(CH_PCT);
					2: chars.push_back(CH_PLUS);
					default: ;
				endcase
			end else begin
				chars.push_back(8'($urandom_range(0, 255)));
			end
		end
		foreach (chars[i]) begin
			send_char(row(chars[i], i == chars.size() - 1));
			pace();
		end
	endtask

	// Receiver. It drives ready from its own pattern, which rotates between always
	// ready, two kinds of random stall and a fixed one in three cadence. On request
	// it holds ready low for a long stretch so that the block's internal queue fills
	// and the input side stalls.
	initial begin : receiver
		int   rx_cycle;
		logic rdy;
		dec_bus.ready = 1'b0;
		rx_cycle      = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				dec_bus.ready <= 1'b0;
				hold_req      <= 1'b0;
				holds_done++;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					@(posedge clk);
				end
			end else begin
				case ((rx_cycle / 97) % 4)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 99) < 60);
					2: rdy = (rx_cycle % 3 == 0);
					default: rdy = ($urandom_range(0, 99) < 25);
				endcase
				dec_bus.ready <= rdy;
				rx_cycle++;
			end
		end
	end

	// Checker. Every decoded item that leaves the block is compared with the
	// oldest expectation. Values are read at the edge, before any of the
	// nonblocking updates of that edge take effect.
	always @(posedge clk) begin
		dec_item_t want;
		if (arst_n && dec_bus.valid && dec_bus.ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t ns: decoded item with none expected: out_byte %02h out_last %b",
					$time, dec_bus.out_byte, dec_bus.out_last);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				results_checked++;
				if (dec_bus.out_byte !== want.data) begin
					$display("%0t ns: out_byte expected %02h, actual %02h",
						$time, want.data, dec_bus.out_byte);
					errors++;
				end
				if (dec_bus.out_last !== want.last) begin
					$display("%0t ns: out_last expected %b, actual %b (out_byte %02h)",
						$time, want.last, dec_bus.out_last, dec_bus.out_byte);
					errors++;
				end
			end
		end
	end

	// Watchdog. A correct run never goes this long without any item moving on
	// either channel, so reaching the limit means the block has hung.
	always @(posedge clk) begin
		int idle_cycles;
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((enc_bus.valid && enc_bus.ready) || (dec_bus.valid && dec_bus.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no item moved for %0d cycles, %0d decoded items outstanding",
					$time, idle_cycles, expected_bytes.size());
				$display("url_percent_decoder test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		stim_row_t directed [$];
		int        random_base;
		bit        hold_sent;
		bit        drain_sent;

		errors          = 0;
		items_sent      = 0;
		strings_sent    = 0;
		results_checked = 0;
		holds_done      = 0;
		drains_done     = 0;
		burst_left      = 0;
		no_gap_left     = 0;
		drain_req       = 1'b0;
		hold_req        = 1'b0;
		hold_sent       = 1'b0;
		drain_sent      = 1'b0;
		esc_phase       = PH_PLAIN;
		held_char       = 8'h00;

		arst_n          = 1'b0;
		enc_bus.valid   = 1'b0;
		enc_bus.in_byte = 8'h00;
		enc_bus.in_last = 1'b0;

		// Directed part. Rows with a count give the decoded bytes outright;
		// the others are worked out by the predictor. It covers the byte
		// extremes, a zero byte passing through, '+', escapes in both cases at
		// the digit boundaries, escapes broken right after '%' and after one
		// digit (by a non-digit, by '+' and by a new '%'), and the end of a
		// string with a bare '%' or a '%' and one digit still open.
		directed = '{
			row(8'h00, 1'b0, 1, 8'h00),
			row(8'hFF, 1'b0, 1, 8'hFF),
			row(CH_PLUS, 1'b0, 1, CH_SPACE),
			row(CH_PCT, 1'b0, 0),
			row("4", 1'b0),
			row("1", 1'b0),
			row(CH_PCT, 1'b0),
			row("f", 1'b0),
			row("F", 1'b0),
			row(CH_PCT, 1'b0),
			row("G", 1'b0, 2, CH_PCT, "G"),
			row(CH_PCT, 1'b0),
			row("9", 1'b0),
			row("@", 1'b0, 3, CH_PCT, "9", "@"),
			row(CH_PCT, 1'b0),
			row(CH_PCT, 1'b0, 1, CH_PCT),
			row(CH_PLUS, 1'b0, 2, CH_PCT, CH_SPACE),
			row(CH_PCT, 1'b0),
			row("a", 1'b0),
			row(CH_PCT, 1'b0, 2, CH_PCT, "a"),
			row("0", 1'b1, 2, CH_PCT, "0"),
			row(CH_PCT, 1'b1, 1, CH_PCT),
			row(CH_PCT, 1'b0),
			row("B", 1'b1),
			row("Z", 1'b1, 1, "Z"),
			row(CH_PCT, 1'b0),
			row("/", 1'b0, 2, CH_PCT, "/")
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_char(directed[i]);
			pace();
		end

		// Random part, whole strings at a time.
		random_base = items_sent;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			if (!hold_sent && items_sent - random_base >= 120) begin
				// Long receiver hold-off while the sender keeps offering items.
				hold_req   <= 1'b1;
				no_gap_left = 40;
				hold_sent   = 1'b1;
			end
			if (!drain_sent && items_sent - random_base >= 250) begin
				drain_req  = 1'b1;
				drain_sent = 1'b1;
			end
			send_random_string();
		end

		// pace() either lowered valid and let time pass, or left it alone, so
		// this is the only assignment to valid in the current time step.
		enc_bus.valid <= 1'b0;

		while (expected_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_bytes.size() != 0) begin
			$display("%0t ns: %0d decoded items never arrived", $time, expected_bytes.size());
			errors += expected_bytes.size();
		end

		$display("Sent %0d encoded items in %0d strings; checked %0d decoded items.",
			items_sent, strings_sent, results_checked);
		$display("Receiver hold-offs: %0d, sender drain pauses: %0d, mismatches: %0d.",
			holds_done, drains_done, errors);
		if (errors == 0) begin
			$display("url_percent_decoder test passed");
		end else begin
			$display("url_percent_decoder test failed");
		end
		$finish;
	end

endmodule
